// ===== rtl/cdi_pkg.sv =====
`timescale 1ns / 1ps

package cdi_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned WdW    = 3;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned MaskW  = 7;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned CfgIdxW = 1;

  // Year shifted by 400 for the weekday sum, and its quotient by 100.
  localparam int unsigned ShYearW = 15;
  localparam int unsigned CentW   = 8;

  localparam logic [ShYearW-1:0] YearShift  = 15'd400;
  localparam logic [DoyW-1:0]    YearLen    = 9'd365;
  localparam logic [DoyW-1:0]    LeapLen    = 9'd366;
  localparam logic [DayW-1:0]    FebLen     = 5'd28;
  localparam logic [DayW-1:0]    FebLeapLen = 5'd29;
  localparam logic [MonthW-1:0]  MonthDec   = 4'd12;
  localparam logic [WdW-1:0]     DaysWeek   = 3'd7;

  localparam logic [MaskW-1:0] WeekendMaskRst = 7'd96;
  localparam logic [WdW-1:0]   LastWeekdayRst = 3'd6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWeekendMask = 1'b0,
    CfgLastWeekday = 1'b1
  } cfg_idx_e;

  // Days of the months before this one, common year.
  function automatic logic [DoyW-1:0] cum_days(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      default: r = 9'd334;
    endcase
    return r;
  endfunction

  // Month length, common year.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd2:    r = 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // floor(31 * m' / 12), where m' counts March as 1 and February as 12.
  function automatic logic [DayW-1:0] month_term(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd2;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd7;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd12;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd23;
      default: r = 5'd25;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/calendar_date_info.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                                        | Handshake
// ---------+----------------------------------------------+---------------------------
// date in  | year_i, month_i, day_i                       | start_i high, busy_o low
// info out | weekday_o .. date_valid_o                    | done_o high for one cycle
// config   | cfg_we_i, cfg_idx_i, cfg_wdata_i             | cfg_we_i high, no wait
//
// A word is taken every cycle; busy_o stays low. Results pass through the input
// register and three stages: divide by 100, leap and weekday sum, then mod 7
// and the day counts.
// Reset clears the stage valid bits and loads the weekend mask and last weekday.
// The receiver cannot stall; done_o words must be taken as they appear.

module calendar_date_info (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [cdi_pkg::YearW-1:0]     year_i,
  input  logic [cdi_pkg::MonthW-1:0]    month_i,
  input  logic [cdi_pkg::DayW-1:0]      day_i,
  input  logic                          cfg_we_i,
  input  logic [cdi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cdi_pkg::CfgW-1:0]      cfg_wdata_i,
  output logic                          done_o,
  output logic [cdi_pkg::WdW-1:0]       weekday_o,
  output logic                          leap_year_o,
  output logic [cdi_pkg::DoyW-1:0]      day_of_year_o,
  output logic                          end_of_week_o,
  output logic                          weekend_o,
  output logic                          business_day_o,
  output logic [cdi_pkg::WdW-1:0]       days_to_week_end_o,
  output logic [cdi_pkg::DayW-1:0]      days_to_month_end_o,
  output logic [cdi_pkg::DoyW-1:0]      days_to_year_end_o,
  output logic                          date_valid_o
);

  localparam int unsigned YW = cdi_pkg::ShYearW;
  localparam int unsigned CW = cdi_pkg::CentW;
  localparam int unsigned FoldW = 6;
  localparam int unsigned Fold2W = 4;

  logic [cdi_pkg::MaskW-1:0] weekend_mask_q;
  logic [cdi_pkg::WdW-1:0]   last_weekday_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weekend_mask_q <= cdi_pkg::WeekendMaskRst;
      last_weekday_q <= cdi_pkg::LastWeekdayRst;
    end else if (cfg_we_i) begin
      unique case (cdi_pkg::cfg_idx_e'(cfg_idx_i))
        cdi_pkg::CfgWeekendMask: weekend_mask_q <= cfg_wdata_i[cdi_pkg::MaskW-1:0];
        cdi_pkg::CfgLastWeekday: last_weekday_q <= cfg_wdata_i[cdi_pkg::WdW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // Input register
  logic                       s0_vld_q;
  logic [cdi_pkg::YearW-1:0]  s0_year_q;
  logic [cdi_pkg::MonthW-1:0] s0_month_q;
  logic [cdi_pkg::DayW-1:0]   s0_day_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s0_year_q  <= year_i;
      s0_month_q <= month_i;
      s0_day_q   <= day_i;
    end
  end

  // Stage 1: normalize month, shift year, divide by 100
  logic                       s1_ok_d;
  logic [cdi_pkg::MonthW-1:0] s1_mon_d;
  logic                       s1_jf_d;
  logic [YW-1:0]              s1_y_d;
  logic [CW-1:0]              s1_qy_d;
  logic [CW-1:0]              s1_qyr_d;

  assign s1_ok_d  = (s0_month_q != '0) && (s0_month_q <= cdi_pkg::MonthDec);
  assign s1_mon_d = s1_ok_d ? s0_month_q : cdi_pkg::MonthDec;
  assign s1_jf_d  = (s1_mon_d <= cdi_pkg::MonthW'(2));
  assign s1_y_d   = YW'(s0_year_q) + cdi_pkg::YearShift - YW'(s1_jf_d);

  cdi_div100 u_div_shifted (
    .num_i (s1_y_d),
    .quo_o (s1_qy_d)
  );

  cdi_div100 u_div_year (
    .num_i (YW'(s0_year_q)),
    .quo_o (s1_qyr_d)
  );

  logic                       s1_vld_q;
  logic [cdi_pkg::YearW-1:0]  s1_year_q;
  logic [CW-1:0]              s1_qyr_q;
  logic [YW-1:0]              s1_y_q;
  logic [CW-1:0]              s1_qy_q;
  logic [cdi_pkg::DayW-1:0]   s1_day_q;
  logic                       s1_ok_q;
  logic                       s1_feb_q;
  logic                       s1_late_q;
  logic [cdi_pkg::DayW-1:0]   s1_mterm_q;
  logic [cdi_pkg::DoyW-1:0]   s1_cum_q;
  logic [cdi_pkg::DayW-1:0]   s1_mlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_vld_q) begin
      s1_year_q  <= s0_year_q;
      s1_qyr_q   <= s1_qyr_d;
      s1_y_q     <= s1_y_d;
      s1_qy_q    <= s1_qy_d;
      s1_day_q   <= s0_day_q;
      s1_ok_q    <= s1_ok_d;
      s1_feb_q   <= (s1_mon_d == cdi_pkg::MonthW'(2));
      s1_late_q  <= !s1_jf_d;
      s1_mterm_q <= cdi_pkg::month_term(s1_mon_d);
      s1_cum_q   <= cdi_pkg::cum_days(s1_mon_d);
      s1_mlen_q  <= cdi_pkg::month_len(s1_mon_d);
    end
  end

  // Stage 2: leap flag, weekday sum, day of year base
  logic [cdi_pkg::YearW-1:0] s2_hund_d;
  logic                      s2_cent_d;
  logic                      s2_leap_d;
  logic [YW-1:0]             s2_wsum_d;
  logic [cdi_pkg::DoyW-1:0]  s2_doy_d;
  logic [cdi_pkg::DayW-1:0]  s2_mlen_d;

  assign s2_hund_d = cdi_pkg::YearW'(s1_qyr_q) * cdi_pkg::YearW'(100);
  assign s2_cent_d = (s1_year_q == s2_hund_d);
  assign s2_leap_d = ((s1_year_q[1:0] == 2'd0) && !s2_cent_d)
                  || (s2_cent_d && (s1_qyr_q[1:0] == 2'd0));
  assign s2_wsum_d = YW'(s1_day_q) + s1_y_q + (s1_y_q >> 2) - YW'(s1_qy_q)
                   + YW'(s1_qy_q >> 2) + YW'(s1_mterm_q);
  assign s2_doy_d  = s1_cum_q + cdi_pkg::DoyW'(s1_day_q);
  assign s2_mlen_d = s1_feb_q ? (s2_leap_d ? cdi_pkg::FebLeapLen : cdi_pkg::FebLen)
                              : s1_mlen_q;

  logic                      s2_vld_q;
  logic [YW-1:0]             s2_wsum_q;
  logic                      s2_leap_q;
  logic [cdi_pkg::DoyW-1:0]  s2_doy_q;
  logic                      s2_late_q;
  logic [cdi_pkg::DayW-1:0]  s2_mlen_q;
  logic [cdi_pkg::DayW-1:0]  s2_day_q;
  logic                      s2_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_wsum_q <= s2_wsum_d;
      s2_leap_q <= s2_leap_d;
      s2_doy_q  <= s2_doy_d;
      s2_late_q <= s1_late_q;
      s2_mlen_q <= s2_mlen_d;
      s2_day_q  <= s1_day_q;
      s2_ok_q   <= s1_ok_q;
    end
  end

  // Stage 3: mod 7 by octal digit folding, day counts, config lookups
  logic [FoldW-1:0]          fold1;
  logic [Fold2W-1:0]         fold2;
  logic [cdi_pkg::WdW-1:0]   wd_d;
  logic [cdi_pkg::WdW-1:0]   last_eff;
  logic [Fold2W-1:0]         to_week_sum;
  logic [cdi_pkg::WdW-1:0]   to_week_d;
  logic [cdi_pkg::DoyW-1:0]  ylen;
  logic [cdi_pkg::DoyW-1:0]  doy_adj;
  logic [cdi_pkg::DoyW-1:0]  doy_d;
  logic [cdi_pkg::DayW-1:0]  to_month_d;
  logic                      valid_d;
  logic                      wkend_d;

  assign fold1 = FoldW'(s2_wsum_q[2:0]) + FoldW'(s2_wsum_q[5:3]) + FoldW'(s2_wsum_q[8:6])
               + FoldW'(s2_wsum_q[11:9]) + FoldW'(s2_wsum_q[14:12]);
  assign fold2 = Fold2W'(fold1[2:0]) + Fold2W'(fold1[5:3]);
  assign wd_d  = (fold2 >= Fold2W'(cdi_pkg::DaysWeek))
               ? cdi_pkg::WdW'(fold2 - Fold2W'(cdi_pkg::DaysWeek))
               : cdi_pkg::WdW'(fold2);

  assign last_eff    = (last_weekday_q == cdi_pkg::DaysWeek) ? '0 : last_weekday_q;
  assign to_week_sum = Fold2W'(last_eff) + Fold2W'(cdi_pkg::DaysWeek) - Fold2W'(wd_d);
  assign to_week_d   = (to_week_sum >= Fold2W'(cdi_pkg::DaysWeek))
                     ? cdi_pkg::WdW'(to_week_sum - Fold2W'(cdi_pkg::DaysWeek))
                     : cdi_pkg::WdW'(to_week_sum);

  assign ylen    = s2_leap_q ? cdi_pkg::LeapLen : cdi_pkg::YearLen;
  assign doy_adj = s2_doy_q + cdi_pkg::DoyW'(s2_leap_q && s2_late_q);
  assign doy_d   = (doy_adj > ylen) ? ylen : doy_adj;

  assign to_month_d = (s2_mlen_q > s2_day_q) ? (s2_mlen_q - s2_day_q) : '0;
  assign valid_d    = s2_ok_q && (s2_day_q != '0) && (s2_day_q <= s2_mlen_q);
  assign wkend_d    = weekend_mask_q[wd_d];

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      weekday_o           <= wd_d;
      leap_year_o         <= s2_leap_q;
      day_of_year_o       <= doy_d;
      end_of_week_o       <= (wd_d == last_weekday_q);
      weekend_o           <= wkend_d;
      business_day_o      <= !wkend_d;
      days_to_week_end_o  <= to_week_d;
      days_to_month_end_o <= to_month_d;
      days_to_year_end_o  <= ylen - doy_d;
      date_valid_o        <= valid_d;
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/cdi_div100.sv =====
`timescale 1ns / 1ps

module cdi_div100 (
  input  logic [cdi_pkg::ShYearW-1:0] num_i,
  output logic [cdi_pkg::CentW-1:0]   quo_o
);

  localparam int unsigned RecipW = 13;
  localparam int unsigned Shift  = 19;
  localparam int unsigned ProdW  = cdi_pkg::ShYearW + RecipW;
  localparam logic [RecipW-1:0] Recip = 13'd5243;

  logic [ProdW-1:0] prod;

  // 5243 / 2^19 is exact for floor(n / 100) over the 15-bit range; quo_o keeps its low 8 bits
  assign prod  = ProdW'(num_i) * ProdW'(Recip);
  assign quo_o = prod[Shift +: cdi_pkg::CentW];

endmodule

// ===== bench/calendar_date_info_tb.sv =====
`timescale 1ns / 1ps

module calendar_date_info_tb;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandPerPhase = 350;

  typedef struct packed {
    logic [cdi_pkg::WdW-1:0]  weekday;
    logic                     leap_year;
    logic [cdi_pkg::DoyW-1:0] day_of_year;
    logic                     end_of_week;
    logic                     weekend;
    logic                     business_day;
    logic [cdi_pkg::WdW-1:0]  days_to_week_end;
    logic [cdi_pkg::DayW-1:0] days_to_month_end;
    logic [cdi_pkg::DoyW-1:0] days_to_year_end;
    logic                     date_valid;
  } date_info_t;

  class date_info_book;
    bit [cdi_pkg::MaskW-1:0] weekend_mask;
    bit [cdi_pkg::WdW-1:0]   last_weekday;
    date_info_t              pending[$];
    int unsigned             errors;

    function new();
      weekend_mask = cdi_pkg::WeekendMaskRst;
      last_weekday = cdi_pkg::LastWeekdayRst;
      errors = 0;
    endfunction

    static function bit is_leap(int unsigned yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    static function int unsigned month_days(int unsigned yr, int unsigned mo);
      int unsigned len_tab[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (mo == 2) begin
        return is_leap(yr) ? 29 : 28;
      end
      return len_tab[(mo - 1) % 12];
    endfunction

    function date_info_t info_of(int unsigned yr, int unsigned mo_raw, int unsigned dy);
      date_info_t  r;
      bit          mo_ok;
      bit          leap;
      bit          wkend;
      int unsigned mo, ylen, mlen, cum, doy, a, y, m, wd;
      mo_ok = (mo_raw >= 1) && (mo_raw <= 12);
      mo    = mo_ok ? mo_raw : 12;
      leap  = is_leap(yr);
      ylen  = leap ? 366 : 365;
      mlen  = month_days(yr, mo);
      cum   = 0;
      for (int unsigned i = 1; i < mo; i++) begin
        cum += month_days(yr, i);
      end
      doy = cum + dy;
      if (doy > ylen) begin
        doy = ylen;
      end
      a  = (mo <= 2) ? 1 : 0;
      y  = yr + 400 - a;
      m  = mo + 12 * a - 2;
      wd = (dy + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7;
      wkend = weekend_mask[wd];
      r.weekday           = wd[cdi_pkg::WdW-1:0];
      r.leap_year         = leap;
      r.day_of_year       = doy[cdi_pkg::DoyW-1:0];
      r.end_of_week       = (wd == last_weekday);
      r.weekend           = wkend;
      r.business_day      = ~wkend;
      r.days_to_week_end  = cdi_pkg::WdW'((last_weekday + 7 - wd) % 7);
      r.days_to_month_end = cdi_pkg::DayW'((mlen > dy) ? mlen - dy : 0);
      r.days_to_year_end  = cdi_pkg::DoyW'((ylen > doy) ? ylen - doy : 0);
      r.date_valid        = mo_ok && (dy >= 1) && (dy <= mlen);
      return r;
    endfunction

    function void note_date(int unsigned yr, int unsigned mo, int unsigned dy);
      pending.push_back(info_of(yr, mo, dy));
    endfunction

    function void field_ok(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_info(date_info_t got);
      date_info_t exp_i;
      if (pending.size() == 0) begin
        $error("info word with no date pending");
        errors++;
        return;
      end
      exp_i = pending.pop_front();
      field_ok("weekday", exp_i.weekday, got.weekday);
      field_ok("leap_year", exp_i.leap_year, got.leap_year);
      field_ok("day_of_year", exp_i.day_of_year, got.day_of_year);
      field_ok("end_of_week", exp_i.end_of_week, got.end_of_week);
      field_ok("weekend", exp_i.weekend, got.weekend);
      field_ok("business_day", exp_i.business_day, got.business_day);
      field_ok("days_to_week_end", exp_i.days_to_week_end, got.days_to_week_end);
      field_ok("days_to_month_end", exp_i.days_to_month_end, got.days_to_month_end);
      field_ok("days_to_year_end", exp_i.days_to_year_end, got.days_to_year_end);
      field_ok("date_valid", exp_i.date_valid, got.date_valid);
    endfunction

    function int unsigned pending_count();
      return pending.size();
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [cdi_pkg::YearW-1:0]   year_i;
  logic [cdi_pkg::MonthW-1:0]  month_i;
  logic [cdi_pkg::DayW-1:0]    day_i;
  logic                        cfg_we_i;
  logic [cdi_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [cdi_pkg::CfgW-1:0]    cfg_wdata_i;
  logic                        done_o;
  logic [cdi_pkg::WdW-1:0]     weekday_o;
  logic                        leap_year_o;
  logic [cdi_pkg::DoyW-1:0]    day_of_year_o;
  logic                        end_of_week_o;
  logic                        weekend_o;
  logic                        business_day_o;
  logic [cdi_pkg::WdW-1:0]     days_to_week_end_o;
  logic [cdi_pkg::DayW-1:0]    days_to_month_end_o;
  logic [cdi_pkg::DoyW-1:0]    days_to_year_end_o;
  logic                        date_valid_o;

  date_info_book board = new();
  int unsigned   idle_cycles = 0;
  bit            burst = 1'b0;

  calendar_date_info i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .year_i             (year_i),
    .month_i            (month_i),
    .day_i              (day_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .weekday_o          (weekday_o),
    .leap_year_o        (leap_year_o),
    .day_of_year_o      (day_of_year_o),
    .end_of_week_o      (end_of_week_o),
    .weekend_o          (weekend_o),
    .business_day_o     (business_day_o),
    .days_to_week_end_o (days_to_week_end_o),
    .days_to_month_end_o(days_to_month_end_o),
    .days_to_year_end_o (days_to_year_end_o),
    .date_valid_o       (date_valid_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      board.check_info('{weekday_o, leap_year_o, day_of_year_o, end_of_week_o, weekend_o,
                         business_day_o, days_to_week_end_o, days_to_month_end_o,
                         days_to_year_end_o, date_valid_o});
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("calendar_date_info verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_date(int unsigned yr, int unsigned mo, int unsigned dy, int unsigned gap);
    start_i <= 1'b1;
    year_i  <= cdi_pkg::YearW'(yr);
    month_i <= cdi_pkg::MonthW'(mo);
    day_i   <= cdi_pkg::DayW'(dy);
    do @(posedge clk_i); while (busy_o);
    board.note_date(yr, mo, dy);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_cfg(cdi_pkg::cfg_idx_e idx, int unsigned data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= cdi_pkg::CfgW'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == cdi_pkg::CfgWeekendMask) begin
      board.weekend_mask = cdi_pkg::MaskW'(data);
    end else begin
      board.last_weekday = cdi_pkg::WdW'(data);
    end
    @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_random_dates(int unsigned count);
    int unsigned yr, mo, dy, len, pick, gap;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        yr = $urandom_range(1, 9999);
      end else if (pick < 90) begin
        yr = 0;
      end else begin
        yr = $urandom_range(0, (1 << cdi_pkg::YearW) - 1);
      end
      mo = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12)
                                       : $urandom_range(0, (1 << cdi_pkg::MonthW) - 1);
      len  = date_info_book::month_days(yr, mo);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        dy = $urandom_range(1, len);
      end else if (pick < 85) begin
        dy = len;
      end else begin
        dy = $urandom_range(0, (1 << cdi_pkg::DayW) - 1);
      end
      if ($urandom_range(0, 31) == 0) begin
        burst = ~burst;
      end
      gap = burst ? 0 : $urandom_range(0, 15);
      send_date(yr, mo, dy, gap);
    end
  endtask

  initial begin
    int unsigned dir_year[25] = '{1, 0, 0, 9999, 16383, 1600, 1700, 1900, 2000, 2000, 2023,
                                  2024, 2024, 2024, 2024, 2024, 2023, 1970, 2024, 100, 400,
                                  8191, 2024, 2025, 2025};
    int unsigned dir_month[25] = '{1, 1, 2, 12, 15, 2, 2, 2, 2, 12, 2, 1, 3, 4, 0, 13, 12, 1, 2,
                                   2, 2, 7, 6, 2, 14};
    int unsigned dir_day[25] = '{1, 1, 29, 31, 31, 29, 29, 28, 29, 31, 29, 0, 0, 31, 15, 1, 31,
                                 1, 30, 29, 29, 4, 30, 28, 0};
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    year_i      <= '0;
    month_i     <= '0;
    day_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= cdi_pkg::CfgWeekendMask;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned n = 0; n < 25; n++) begin
      send_date(dir_year[n], dir_month[n], dir_day[n], 0);
    end
    send_random_dates(RandPerPhase);
    drain();

    write_cfg(cdi_pkg::CfgWeekendMask, 0);
    write_cfg(cdi_pkg::CfgLastWeekday, 0);
    send_random_dates(RandPerPhase);
    drain();

    write_cfg(cdi_pkg::CfgWeekendMask, 7'h7f);
    write_cfg(cdi_pkg::CfgLastWeekday, 7'h7f);
    send_random_dates(RandPerPhase);
    drain();

    for (int unsigned ph = 0; ph < 2; ph++) begin
      write_cfg(cdi_pkg::CfgLastWeekday, $urandom_range(0, 127));
      write_cfg(cdi_pkg::CfgWeekendMask, $urandom_range(0, 127));
      send_random_dates(RandPerPhase);
      drain();
    end

    if (board.errors == 0 && board.pending_count() == 0) begin
      $display("calendar_date_info verification clean");
    end else begin
      $display("calendar_date_info verification failed");
    end
    $finish;
  end

endmodule
